// ----- hdl/tlfa_pkg.sv -----
// Shared types, constants and tables for the thresholded line fit block.
// Used by tlfa_acc, tlfa_mdu, tlfa_cordic and the top level.
package tlfa_pkg;

  localparam int IMG_W = 640;
  localparam int IMG_H = 480;

  localparam int CNT_W = 19;
  localparam int SX_W  = 28;
  localparam int SXX_W = 37;
  localparam int COL_W = 10;
  localparam int ROW_W = 9;

  localparam int MUL_W  = 37;
  localparam int PROD_W = 64;
  localparam int DNUM_W = 76;
  localparam int DDEN_W = 58;

  localparam logic [6:0] MUL_STEPS = 7'd37;
  localparam logic [6:0] DIV_STEPS = 7'd76;

  localparam logic [4:0] CORDIC_LAST = 5'd17;

  // slope used when the fit denominator is zero: 2*width in Q16.16
  localparam logic [31:0] VERT_SLOPE = 32'(2 * IMG_W * 65536);

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } mdu_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SX_W-1:0]  sx;
    logic [SX_W-1:0]  sy;
    logic [SXX_W-1:0] sxx;
    logic [SXX_W-1:0] sxy;
  } acc_sums_t;

  // arctangent of 2^-i in degrees, Q16
  function automatic logic [24:0] atan_tab(logic [4:0] idx);
    logic [24:0] v;
    case (idx)
      5'd0:  v = 25'd2949120;
      5'd1:  v = 25'd1740967;
      5'd2:  v = 25'd919879;
      5'd3:  v = 25'd466945;
      5'd4:  v = 25'd234379;
      5'd5:  v = 25'd117304;
      5'd6:  v = 25'd58666;
      5'd7:  v = 25'd29335;
      5'd8:  v = 25'd14668;
      5'd9:  v = 25'd7334;
      5'd10: v = 25'd3667;
      5'd11: v = 25'd1833;
      5'd12: v = 25'd917;
      5'd13: v = 25'd458;
      5'd14: v = 25'd229;
      5'd15: v = 25'd115;
      5'd16: v = 25'd57;
      5'd17: v = 25'd29;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/tlfa_acc.sv -----
// Pixel position counters, dark pixel test and saturating fit sums.
// Depends on tlfa_pkg.
module tlfa_acc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pix_valid_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [8:0]            thr_i,
  input  logic [7:0]            trim_i,
  input  logic                  clear_i,
  output tlfa_pkg::acc_sums_t   sums_o
);
  import tlfa_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  acc_sums_t        sums_q, sums_d;

  logic [9:0]  chan_sum;
  logic [19:0] avg_prod;
  logic [8:0]  avg;
  logic [10:0] col_end;
  logic [10:0] row_end;
  logic        is_point;
  logic [9:0]  py;
  logic [19:0] px_sq;
  logic [19:0] px_py;
  logic [CNT_W:0] n_add;
  logic [SX_W:0]  sx_add, sy_add;
  logic [SXX_W:0] sxx_add, sxy_add;

  always_comb begin
    chan_sum = 10'(red_i) + 10'(green_i) + 10'(blue_i);
    // divide by 3 through the reciprocal 683/2048, exact for sums up to 765
    avg_prod = 20'(chan_sum) * 20'd683;
    avg      = avg_prod[19:11];
    col_end  = 11'(col_q) + 11'(trim_i);
    row_end  = 11'(row_q) + 11'(trim_i);
    is_point = (10'(row_q) > 10'(trim_i)) && (col_q > 10'(trim_i)) &&
               (row_end < 11'(IMG_H)) && (col_end < 11'(IMG_W)) && (avg < thr_i);
    py       = 10'(IMG_H) - 10'(row_q);
    px_sq    = 20'(col_q) * 20'(col_q);
    px_py    = 20'(col_q) * 20'(py);

    n_add   = {1'b0, sums_q.n} + (CNT_W+1)'(1);
    sx_add  = {1'b0, sums_q.sx} + (SX_W+1)'(col_q);
    sy_add  = {1'b0, sums_q.sy} + (SX_W+1)'(py);
    sxx_add = {1'b0, sums_q.sxx} + (SXX_W+1)'(px_sq);
    sxy_add = {1'b0, sums_q.sxy} + (SXX_W+1)'(px_py);

    sums_d = sums_q;
    col_d  = col_q;
    row_d  = row_q;
    if (clear_i) begin
      sums_d = '0;
      col_d  = '0;
      row_d  = '0;
    end else if (pix_valid_i) begin
      if (is_point) begin
        sums_d.n   = n_add[CNT_W] ? '1 : n_add[CNT_W-1:0];
        sums_d.sx  = sx_add[SX_W] ? '1 : sx_add[SX_W-1:0];
        sums_d.sy  = sy_add[SX_W] ? '1 : sy_add[SX_W-1:0];
        sums_d.sxx = sxx_add[SXX_W] ? '1 : sxx_add[SXX_W-1:0];
        sums_d.sxy = sxy_add[SXX_W] ? '1 : sxy_add[SXX_W-1:0];
      end
      if (col_q == COL_W'(IMG_W - 1)) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(IMG_H - 1)) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      sums_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

// ----- hdl/tlfa_mdu.sv -----
// Shared iterative unit: shift-add multiply, one bit per cycle, and restoring
// divide with a 32-bit quotient and an overflow flag. Depends on tlfa_pkg.
module tlfa_mdu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlfa_pkg::mdu_req_t            req_i,
  input  logic [tlfa_pkg::MUL_W-1:0]    mul_a_i,
  input  logic [tlfa_pkg::MUL_W-1:0]    mul_b_i,
  input  logic [tlfa_pkg::DNUM_W-1:0]   div_num_i,
  input  logic [tlfa_pkg::DDEN_W-1:0]   div_den_i,
  output tlfa_pkg::mdu_rsp_t            rsp_o,
  output logic [tlfa_pkg::PROD_W-1:0]   prod_o,
  output logic [31:0]                   quot_o
);
  import tlfa_pkg::*;

  logic              busy_q, done_q, ovf_q;
  mdu_op_e           op_q;
  logic [6:0]        cnt_q;
  logic [PROD_W-1:0] a_q, p_q;
  logic [MUL_W-1:0]  b_q;
  logic [DNUM_W-1:0] num_q;
  logic [DDEN_W-1:0] den_q, rem_q;
  logic [31:0]       quo_q;

  logic [DDEN_W:0]   r_sh, r_sub;
  logic              ge;

  always_comb begin
    r_sh  = {rem_q, num_q[DNUM_W-1]};
    ge    = r_sh >= {1'b0, den_q};
    r_sub = r_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MDU_MUL;
      ovf_q  <= 1'b0;
      a_q    <= '0;
      p_q    <= '0;
      b_q    <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        a_q    <= PROD_W'(mul_a_i);
        b_q    <= mul_b_i;
        p_q    <= '0;
        num_q  <= div_num_i;
        den_q  <= div_den_i;
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        cnt_q  <= (req_i.op == MDU_MUL) ? MUL_STEPS : DIV_STEPS;
      end else if (busy_q) begin
        if (op_q == MDU_MUL) begin
          if (b_q[0]) p_q <= p_q + a_q;
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end else begin
          rem_q <= ge ? r_sub[DDEN_W-1:0] : r_sh[DDEN_W-1:0];
          num_q <= num_q << 1;
          quo_q <= {quo_q[30:0], ge};
          ovf_q <= ovf_q | quo_q[31];
        end
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q | quo_q[31];
  assign prod_o     = p_q;
  assign quot_o     = quo_q;

endmodule

// ----- hdl/tlfa_cordic.sv -----
// Iterative CORDIC in vectoring mode, one micro-rotation per cycle, giving the
// negated arctangent of a Q16.16 slope in 1/256 degree. Depends on tlfa_pkg.
module tlfa_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] slope_i,
  output logic        done_o,
  output logic [15:0] angle_o
);
  import tlfa_pkg::*;

  logic               busy_q, fin_q, done_q;
  logic [4:0]         cnt_q;
  logic signed [35:0] x_q, y_q;
  logic signed [24:0] z_q;
  logic [15:0]        angle_q;

  logic signed [35:0] xs, ys;
  logic               pos;
  logic [24:0]        tab;
  logic [24:0]        zabs;
  logic [16:0]        mag_full;
  logic [15:0]        mag;

  always_comb begin
    xs       = x_q >>> cnt_q;
    ys       = y_q >>> cnt_q;
    pos      = !y_q[35] && (y_q != '0);
    tab      = atan_tab(cnt_q);
    zabs     = z_q[24] ? 25'(-z_q) : 25'(z_q);
    mag_full = 17'((zabs + 25'd128) >> 8);
    mag      = (mag_full > 17'd23040) ? 16'd23040 : mag_full[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      angle_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        x_q    <= 36'sd65536;
        y_q    <= 36'(signed'(slope_i));
        z_q    <= '0;
      end else if (busy_q) begin
        if (pos) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + signed'(tab);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - signed'(tab);
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == CORDIC_LAST) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        // round half away from zero, then negate
        angle_q <= z_q[24] ? mag : 16'(-mag);
        fin_q   <= 1'b0;
        done_q  <= 1'b1;
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

// ----- hdl/thresholded_line_fit_angle.sv -----
// Thresholded line fit: pixels are taken one per cycle while idle; the item
// marked frame_end starts the fit, which runs on the shared bit-serial
// multiply/divide unit (five multiplies, up to two divides) and then on the
// CORDIC. The result then waits for the sink.
// Reset: threshold 128, border trim 10, counters and sums cleared.
module thresholded_line_fit_angle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] angle_deg_o,
  output logic signed [31:0] slope_fix_o,
  output logic signed [31:0] intercept_fix_o,
  output logic [18:0]        point_total_o,
  output logic               vertical_flag_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  import tlfa_pkg::*;

  localparam logic [7:0] CFG_THRESHOLD = 8'd0;
  localparam logic [7:0] CFG_TRIM      = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ANGLE,
    ST_ANGLE_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    STP_NSXY,
    STP_SXSY,
    STP_NSXX,
    STP_SXSX,
    STP_SLOPE,
    STP_SXSL,
    STP_ICPT
  } step_e;

  function automatic logic [31:0] sat_q(logic neg, logic ovf, logic [31:0] q);
    if (ovf) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return neg ? -q : q;
  endfunction

  state_e      state_q;
  step_e       step_q;
  logic [8:0]  thr_q;
  logic [7:0]  trim_q;
  logic [63:0] t1_q, num_q, den_q, icpt_num_q;
  logic [31:0] slope_q, icpt_q;
  logic        neg_q, vert_q;

  logic        in_acc;
  logic        acc_clear;
  acc_sums_t   sums;

  mdu_req_t              mdu_req;
  mdu_rsp_t              mdu_rsp;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [DNUM_W-1:0]     div_num;
  logic [DDEN_W-1:0]     div_den;
  logic [PROD_W-1:0]     prod;
  logic [31:0]           quot;

  logic        cor_start, cor_done;
  logic [15:0] cor_angle;

  logic [63:0] num_abs, den_abs, icpt_abs, sy_q16;
  logic [32:0] slope_abs;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign acc_clear   = (state_q == ST_OUT) && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cor_start   = (state_q == ST_ANGLE);

  always_comb begin
    num_abs   = num_q[63] ? -num_q : num_q;
    den_abs   = den_q[63] ? -den_q : den_q;
    icpt_abs  = icpt_num_q[63] ? -icpt_num_q : icpt_num_q;
    slope_abs = slope_q[31] ? -{1'b1, slope_q} : {1'b0, slope_q};
    sy_q16    = {20'b0, sums.sy, 16'b0};

    mdu_req.start = 1'b0;
    mdu_req.op    = MDU_MUL;
    mul_a         = '0;
    mul_b         = '0;
    div_num       = '0;
    div_den       = '0;
    if (state_q == ST_ISSUE) begin
      case (step_q)
        STP_NSXY: begin
          mdu_req.start = 1'b1;
          mul_a = MUL_W'(sums.n);
          mul_b = sums.sxy;
        end
        STP_SXSY: begin
          mdu_req.start = 1'b1;
          mul_a = MUL_W'(sums.sx);
          mul_b = MUL_W'(sums.sy);
        end
        STP_NSXX: begin
          mdu_req.start = 1'b1;
          mul_a = MUL_W'(sums.n);
          mul_b = sums.sxx;
        end
        STP_SXSX: begin
          mdu_req.start = 1'b1;
          mul_a = MUL_W'(sums.sx);
          mul_b = MUL_W'(sums.sx);
        end
        STP_SLOPE: begin
          mdu_req.start = (den_q != '0);
          mdu_req.op    = MDU_DIV;
          div_num = {num_abs[59:0], 16'b0};
          div_den = den_abs[DDEN_W-1:0];
        end
        STP_SXSL: begin
          mdu_req.start = 1'b1;
          mul_a = MUL_W'(slope_abs);
          mul_b = MUL_W'(sums.sx);
        end
        STP_ICPT: begin
          mdu_req.start = (sums.n != '0);
          mdu_req.op    = MDU_DIV;
          div_num = DNUM_W'(icpt_abs);
          div_den = DDEN_W'(sums.n);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= STP_NSXY;
      thr_q      <= 9'd128;
      trim_q     <= 8'd10;
      t1_q       <= '0;
      num_q      <= '0;
      den_q      <= '0;
      icpt_num_q <= '0;
      slope_q    <= '0;
      icpt_q     <= '0;
      neg_q      <= 1'b0;
      vert_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i;
          CFG_TRIM:      trim_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && frame_end_i) begin
            state_q <= ST_ISSUE;
            step_q  <= STP_NSXY;
            vert_q  <= 1'b0;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
          if (step_q == STP_SLOPE) begin
            if (den_q == '0) begin
              vert_q  <= 1'b1;
              slope_q <= VERT_SLOPE;
              step_q  <= STP_SXSL;
              state_q <= ST_ISSUE;
            end else begin
              neg_q <= num_q[63] ^ den_q[63];
            end
          end else if (step_q == STP_ICPT) begin
            if (sums.n == '0) begin
              icpt_q  <= 32'h0001_0000;
              state_q <= ST_ANGLE;
            end else begin
              neg_q <= icpt_num_q[63];
            end
          end
        end
        ST_WAIT: begin
          if (mdu_rsp.done) begin
            state_q <= ST_ISSUE;
            case (step_q)
              STP_NSXY: begin
                t1_q   <= prod;
                step_q <= STP_SXSY;
              end
              STP_SXSY: begin
                num_q  <= t1_q - prod;
                step_q <= STP_NSXX;
              end
              STP_NSXX: begin
                t1_q   <= prod;
                step_q <= STP_SXSX;
              end
              STP_SXSX: begin
                den_q  <= t1_q - prod;
                step_q <= STP_SLOPE;
              end
              STP_SLOPE: begin
                slope_q <= sat_q(neg_q, mdu_rsp.ovf, quot);
                step_q  <= STP_SXSL;
              end
              STP_SXSL: begin
                icpt_num_q <= slope_q[31] ? sy_q16 + prod : sy_q16 - prod;
                step_q     <= STP_ICPT;
              end
              STP_ICPT: begin
                icpt_q  <= sat_q(neg_q, mdu_rsp.ovf, quot);
                state_q <= ST_ANGLE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ANGLE: state_q <= ST_ANGLE_WAIT;
        ST_ANGLE_WAIT: begin
          if (cor_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  tlfa_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (in_acc),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .thr_i       (thr_q),
    .trim_i      (trim_q),
    .clear_i     (acc_clear),
    .sums_o      (sums)
  );

  tlfa_mdu u_mdu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mdu_req),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .div_num_i (div_num),
    .div_den_i (div_den),
    .rsp_o     (mdu_rsp),
    .prod_o    (prod),
    .quot_o    (quot)
  );

  tlfa_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .slope_i (slope_q),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  assign out_valid_o     = (state_q == ST_OUT);
  assign angle_deg_o     = signed'(cor_angle);
  assign slope_fix_o     = signed'(slope_q);
  assign intercept_fix_o = signed'(icpt_q);
  assign point_total_o   = sums.n;
  assign vertical_flag_o = vert_q;

endmodule

// ----- verif/thresholded_line_fit_angle_test.sv -----
// Testbench for thresholded_line_fit_angle: pixel frames in, line fits out.
// Uses tlfa_pkg for the image size; a scoreboard class predicts each fit.
module thresholded_line_fit_angle_test;
  import tlfa_pkg::*;

  localparam logic [7:0] REG_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_TRIM      = 8'd1;
  localparam int FIT_LATENCY = 400;
  localparam longint CNT_MAX = (64'd1 << 19) - 1;
  localparam longint S28_MAX = (64'd1 << 28) - 1;
  localparam longint S37_MAX = (64'd1 << 37) - 1;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [31:0] slope;
    logic signed [31:0] icpt;
    logic [18:0]        total;
    logic               vert;
  } fit_t;

  class line_fit_scoreboard;
    int unsigned threshold, trim, col, row;
    longint cnt, sx, sy, sxx, sxy;
    fit_t fits_due[$];
    int errors;

    function new();
      threshold = 128;
      trim = 10;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col = 0; row = 0;
      cnt = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [8:0] val);
      if (idx == REG_THRESHOLD) threshold = val;
      else if (idx == REG_TRIM) trim = val[7:0];
    endfunction

    function longint sat_add(longint a, longint b, longint lim);
      return (a + b > lim) ? lim : a + b;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // num*2^16/den truncated toward zero, den > 0
    function longint q16_quotient(longint num, longint den);
      logic neg;
      longint a, ip, r, fr, q;
      neg = num < 0;
      a = neg ? -num : num;
      ip = a / den;
      r = a % den;
      fr = 0;
      if (ip >= (64'd1 << 15)) return neg ? -64'sd2147483648 : 64'sd2147483647;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        fr = fr << 1;
        if (r >= den) begin
          r = r - den;
          fr = fr | 1;
        end
      end
      q = (ip << 16) | fr;
      return sat32(neg ? -q : q);
    endfunction

    function longint slope_angle(longint slope);
      longint x, y, z, nx, mag;
      x = 65536; y = slope; z = 0;
      for (int i = 0; i < 18; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(atan_tab(5'(i)));
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(atan_tab(5'(i)));
        end
        x = nx;
      end
      mag = ((z < 0 ? -z : z) + 128) >> 8;
      if (mag > 23040) mag = 23040;
      return (z < 0) ? mag : -mag;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
      int unsigned avg;
      longint px, py, num, den, slope, icpt;
      fit_t f;
      avg = (int'(r) + int'(g) + int'(b)) / 3;
      if (row > trim && col > trim && row + trim < IMG_H && col + trim < IMG_W &&
          avg < threshold) begin
        px = col;
        py = IMG_H - row;
        cnt = sat_add(cnt, 1, CNT_MAX);
        sx  = sat_add(sx, px, S28_MAX);
        sy  = sat_add(sy, py, S28_MAX);
        sxx = sat_add(sxx, px * px, S37_MAX);
        sxy = sat_add(sxy, px * py, S37_MAX);
      end
      col++;
      if (col >= IMG_W) begin
        col = 0;
        row++;
        if (row >= IMG_H) row = 0;
      end
      if (!last) return;
      num = cnt * sxy - sx * sy;
      den = cnt * sxx - sx * sx;
      f.vert = (den == 0);
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      slope = f.vert ? longint'(2 * IMG_W) * 65536 : q16_quotient(num, den);
      if (cnt > 0) begin
        num = sy * 65536 - slope * sx;
        icpt = sat32((num < 0) ? -((-num) / cnt) : num / cnt);
      end else begin
        icpt = 65536;
      end
      f.angle = 16'(slope_angle(slope));
      f.slope = 32'(slope);
      f.icpt  = 32'(icpt);
      f.total = 19'(cnt);
      fits_due = {fits_due, f};
      clear_frame();
    endfunction

    function void mismatch(string what, longint want, longint got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_fit(fit_t got);
      fit_t want;
      if (fits_due.size() == 0) begin
        mismatch("unexpected fit, slope", 0, got.slope);
        return;
      end
      want = fits_due.pop_front();
      if (got.angle !== want.angle) mismatch("angle_deg", want.angle, got.angle);
      if (got.slope !== want.slope) mismatch("slope_fix", want.slope, got.slope);
      if (got.icpt !== want.icpt) mismatch("intercept_fix", want.icpt, got.icpt);
      if (got.total !== want.total) mismatch("point_total", want.total, got.total);
      if (got.vert !== want.vert) mismatch("vertical_flag", want.vert, got.vert);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] red_i = '0, green_i = '0, blue_i = '0;
  logic frame_end_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [7:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, cfg_ready_o, vertical_flag_o;
  logic signed [15:0] angle_deg_o;
  logic signed [31:0] slope_fix_o, intercept_fix_o;
  logic [18:0] point_total_o;

  logic idle_en = 1'b1;
  logic hold_req = 1'b0;
  logic hold = 1'b0;
  line_fit_scoreboard sb = new();

  thresholded_line_fit_angle uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int stall_left;
    fit_t got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.angle = angle_deg_o;
        got.slope = slope_fix_o;
        got.icpt  = intercept_fix_o;
        got.total = point_total_o;
        got.vert  = vertical_flag_o;
        sb.check_fit(got);
      end
      if (stall_left > 0) stall_left--;
      else if (idle_en && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 14);
      out_stall_i <= hold || (stall_left > 0);
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    red_i       <= r;
    green_i     <= g;
    blue_i      <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(r, g, b, last);
  endtask

  // drop valid and let the clock sample it before anything is driven again
  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(int len, int dark_pct);
    int lim;
    for (int i = 0; i < len; i++) begin
      lim = ($urandom_range(0, 99) < dark_pct) ? $urandom_range(0, 120) : 255;
      send_pixel(8'($urandom_range(0, lim)), 8'($urandom_range(0, lim)),
                 8'($urandom_range(0, lim)), i == len - 1);
    end
    stop_input();
  endtask

  task automatic drain();
    while (sb.fits_due.size() != 0) @(posedge clk_i);
    repeat (FIT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int len;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: nothing gets past a trim of 10 in short frames
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_frame(5, 100);
    drain();
    write_reg(REG_THRESHOLD, 9'd256);
    write_reg(REG_TRIM, 8'd0);
    send_frame(20, 0);  // row zero is on the border, so still no points
    drain();
    write_reg(REG_THRESHOLD, 9'd0);
    send_frame(20, 100);
    drain();
    write_reg(REG_THRESHOLD, 9'd128);
    for (int i = 0; i < 641; i++) send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);  // lone point: zero denominator
    for (int i = 0; i < 640; i++) send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd127, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd127, 8'd127, 8'd127, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    stop_input();
    drain();
    write_reg(REG_TRIM, 8'd239);
    send_frame(20, 100);
    drain();
    write_reg(8'd2 + 8'($urandom_range(0, 253)), 9'($urandom_range(0, 511)));
    write_reg(REG_TRIM, 8'd0);

    for (int f = 0; f < 20; f++) begin
      if (f % 6 == 5) begin
        drain();
        write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ? 9'd256 :
                                 9'($urandom_range(0, 256)));
        write_reg(REG_TRIM, 8'($urandom_range(0, 4)));
      end
      if (f == 10) begin
        hold_req <= 1'b1;
        for (int k = 0; k < 5; k++) send_frame($urandom_range(1, 10), 50);
        hold_req <= 1'b0;
        send_frame(10, 50);
        drain();
      end
      len = $urandom_range(1, 12);
      send_frame(len, $urandom_range(0, 100));
    end

    // quiet tail: short frames with no idling on either side
    drain();
    idle_en <= 1'b0;
    write_reg(REG_THRESHOLD, 9'd256);
    write_reg(REG_TRIM, 8'd0);
    for (int k = 0; k < 3; k++) send_frame($urandom_range(1, 12), 50);
    drain();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
